@@ design/hkts_pkg.sv @@
// ----------------------------------------------------------------------------
// hkts_pkg: shared types and constants for the Held-Karp tour solver
// Cost width, infinity sentinel and sequencer state codes.
// ----------------------------------------------------------------------------
package hkts_pkg;
	localparam int MaxVerticesDefault = 8;
	localparam int CostW = 36;
	localparam int TourCostW = 35;
	localparam int WeightW = 32;
	localparam logic [CostW-1:0] CostInf = {CostW{1'b1}};
	localparam logic [TourCostW-1:0] CostSat = {TourCostW{1'b1}};

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_CLEAR = 12'b000000000010,
		ST_RLX_A = 12'b000000000100,
		ST_RLX_B = 12'b000000001000,
		ST_RLX_C = 12'b000000010000,
		ST_RLX_D = 12'b000000100000,
		ST_CLS_A = 12'b000001000000,
		ST_CLS_B = 12'b000010000000,
		ST_BK_A  = 12'b000100000000,
		ST_BK_B  = 12'b001000000000,
		ST_BK_C  = 12'b010000000000,
		ST_EMIT  = 12'b100000000000
	} state_t;
endpackage

@@ design/held_karp_tour_solver.sv @@
// ----------------------------------------------------------------------------
// held_karp_tour_solver: bitmask dynamic-programming tour solver
// Loads a distance matrix word by word; a solve word runs the subset
// relaxation on one add/compare unit and emits the optimal tour.
// ----------------------------------------------------------------------------
// Loading: one matrix word per cycle, back to back, while idle. A solve with
// n > 2 clears all 2048 table entries (one a cycle), relaxes each (subset, from)
// pair and each target of a reachable from, tries each closing candidate and
// backtracks through the candidates of each step, then emits n words.
// n = 1 emits the cycle after the solve word; n = 2 first reads d(0,1) and d(1,0).
// Throughput: one solve at a time. Reset: vcount_q returns to 8; control idles.
module held_karp_tour_solver (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] row_vertex,
	input  logic [2:0] column_vertex,
	input  logic [hkts_pkg::WeightW-1:0] edge_weight,
	input  logic solve_now,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] tour_vertex,
	output logic [hkts_pkg::TourCostW-1:0] tour_cost,
	output logic last_vertex
);
	import hkts_pkg::*;

	localparam int MAX_VERTICES = MaxVerticesDefault;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES+1);
	localparam int SW = MAX_VERTICES;          // subset width
	localparam int TA = VW + SW;               // table address width
	localparam int TD = MAX_VERTICES << MAX_VERTICES;

	state_t state_q;
	logic [3:0] vcount_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] full_q, s_q, bits_q, prev_q;
	logic [VW-1:0] from_q, to_q, tail_q, v_q;
	logic [CW-1:0] k_q;
	logic [TA-1:0] clr_q;
	logic [CostW-1:0] pt_q, best_q, here_q;
	logic [WeightW-1:0] dist_mem [MAX_VERTICES*MAX_VERTICES];
	logic [WeightW-1:0] dist_rd_q;
	logic [CostW-1:0] tab_mem [TD];
	logic [CostW-1:0] tab_rd_q;
	logic [2:0] stack_q [MAX_VERTICES];
	logic [CostW-1:0] sum;

	// memory ports
	logic [2*VW-1:0] d_ra;
	logic [TA-1:0] t_ra, t_wa;
	logic t_we;
	logic [CostW-1:0] t_wd;
	logic d_we;

	function automatic logic [CW-1:0] clamp_n(input logic [3:0] c);
		if (c == 4'd0) return CW'(1);
		if (32'(c) > MAX_VERTICES) return CW'(MAX_VERTICES);
		return CW'(c);
	endfunction

	assign cfg_ready = state_q == ST_IDLE;
	assign in_ready  = state_q == ST_IDLE;
	assign d_we = in_valid && in_ready && 32'(row_vertex) < MAX_VERTICES
		&& 32'(column_vertex) < MAX_VERTICES;

	// relaxation adder
	assign sum = pt_q + CostW'(dist_rd_q);

	// read address selection
	always_comb begin
		d_ra = {from_q, to_q};
		t_ra = {from_q, s_q};
		unique case (state_q) inside
			ST_RLX_A: t_ra = {from_q, s_q};
			ST_RLX_B, ST_RLX_C: t_ra = {to_q, s_q | (SW'(1) << to_q)};
			ST_CLS_A: begin
				t_ra = {v_q, full_q};
				// tiny tours read d(0,1) then d(1,0)
				d_ra = (n_q <= CW'(2)) ? {from_q, to_q} : {v_q, VW'(0)};
			end
			ST_BK_A: t_ra = {tail_q, prev_q};
			ST_BK_B: begin
				t_ra = {v_q, bits_q};
				d_ra = {v_q, tail_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (d_we) dist_mem[{row_vertex[VW-1:0], column_vertex[VW-1:0]}] <= edge_weight;
		dist_rd_q <= dist_mem[d_ra];
		if (t_we) tab_mem[t_wa] <= t_wd;
		tab_rd_q <= tab_mem[t_ra];
	end

	always_comb begin
		t_we = 1'b0;
		t_wa = clr_q;
		t_wd = CostInf;
		if (state_q == ST_CLEAR) begin
			t_we = 1'b1;
			t_wd = (clr_q == TA'(1)) ? '0 : CostInf;
		end else if (state_q == ST_RLX_D) begin
			t_wa = {to_q, s_q | (SW'(1) << to_q)};
			t_wd = sum;
			// skip targets already in the subset
			t_we = (sum < tab_rd_q) && !s_q[to_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcount_q <= 4'(MAX_VERTICES);
			k_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: if (in_valid && solve_now) begin
					n_q <= clamp_n(vcount_q);
					full_q <= SW'((1 << clamp_n(vcount_q)) - 1);
					clr_q <= '0;
					k_q <= '0;
					stack_q[0] <= 3'd0;
					stack_q[1] <= 3'd1;
					if (clamp_n(vcount_q) <= CW'(2)) begin
						// tiny tours: cost is zero or the 0-1-0 round trip
						from_q <= '0;
						to_q <= VW'(1);
						pt_q <= '0;
						state_q <= (clamp_n(vcount_q) == CW'(1)) ? ST_EMIT : ST_CLS_A;
						best_q <= '0;
					end else state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + TA'(1);
					if (clr_q == TA'(TD-1)) begin
						s_q <= SW'(1);
						from_q <= '0;
						state_q <= ST_RLX_A;
					end
				end
				ST_RLX_A: state_q <= ST_RLX_B;  // table read in flight
				ST_RLX_B: begin
					// tab_rd_q holds cost(from, s)
					pt_q <= tab_rd_q;
					if (!s_q[from_q] || tab_rd_q == CostInf) begin
						if (32'(from_q) + 1 >= 32'(n_q)) begin
							from_q <= '0;
							if (s_q + SW'(1) == full_q) begin
								v_q <= '0;
								best_q <= CostInf;
								tail_q <= '0;
								state_q <= ST_CLS_A;
							end else begin
								s_q <= s_q + SW'(1);
								state_q <= ST_RLX_A;
							end
						end else begin
							from_q <= from_q + VW'(1);
							state_q <= ST_RLX_A;
						end
					end else begin
						to_q <= '0;
						state_q <= ST_RLX_C;
					end
				end
				ST_RLX_C: state_q <= ST_RLX_D;  // dist and target read in flight
				ST_RLX_D: begin
					if (32'(to_q) + 1 >= 32'(n_q)) begin
						if (32'(from_q) + 1 >= 32'(n_q)) begin
							from_q <= '0;
							if (s_q + SW'(1) == full_q) begin
								v_q <= '0;
								best_q <= CostInf;
								tail_q <= '0;
								state_q <= ST_CLS_A;
							end else begin
								s_q <= s_q + SW'(1);
								state_q <= ST_RLX_A;
							end
						end else begin
							from_q <= from_q + VW'(1);
							state_q <= ST_RLX_A;
						end
					end else begin
						to_q <= to_q + VW'(1);
						state_q <= ST_RLX_C;
					end
				end
				ST_CLS_A: state_q <= ST_CLS_B;
				ST_CLS_B: begin
					if (n_q <= CW'(2)) begin
						// d(0,1) read, then d(1,0)
						if (from_q == '0 && to_q == VW'(1)) begin
							pt_q <= '0;
							from_q <= VW'(1);
							to_q <= '0;
							state_q <= ST_CLS_A;
							best_q <= CostW'(dist_rd_q);
						end else begin
							best_q <= best_q + CostW'(dist_rd_q);
							state_q <= ST_EMIT;
						end
					end else begin
						if (tab_rd_q != CostInf &&
							tab_rd_q + CostW'(dist_rd_q) < best_q) begin
							best_q <= tab_rd_q + CostW'(dist_rd_q);
							tail_q <= v_q;
						end
						if (32'(v_q) + 1 >= 32'(n_q)) begin
							bits_q <= full_q;
							prev_q <= full_q;
							state_q <= ST_BK_A;
						end else begin
							v_q <= v_q + VW'(1);
							state_q <= ST_CLS_A;
						end
					end
				end
				ST_BK_A: begin
					// cost(tail, prev) arrives next cycle
					stack_q[VW'(n_q - CW'(1) - k_q)] <= 3'(tail_q);
					bits_q <= bits_q & ~(SW'(1) << tail_q);
					v_q <= '0;
					state_q <= ST_BK_C;
				end
				ST_BK_C: begin
					here_q <= tab_rd_q;
					state_q <= ST_BK_B;
				end
				ST_BK_B: begin
					// two-phase: issue the read for candidate v, compare on the next visit
					if (!clr_q[0]) begin
						clr_q[0] <= 1'b1;
					end else begin
						clr_q[0] <= 1'b0;
						if (bits_q[v_q] && tab_rd_q != CostInf && here_q != CostInf
							&& tab_rd_q + CostW'(dist_rd_q) == here_q) begin
							tail_q <= v_q;
							v_q <= '0;
							k_q <= (k_q + CW'(2) >= n_q) ? '0 : k_q + CW'(1);
							prev_q <= bits_q;
							state_q <= (k_q + CW'(2) >= n_q) ? ST_EMIT : ST_BK_A;
						end else if (32'(v_q) + 1 >= 32'(n_q)) begin
							k_q <= (k_q + CW'(2) >= n_q) ? '0 : k_q + CW'(1);
							prev_q <= bits_q;
							state_q <= (k_q + CW'(2) >= n_q) ? ST_EMIT : ST_BK_A;
						end else begin
							v_q <= v_q + VW'(1);
						end
					end
				end
				ST_EMIT: if (out_ready) begin
					if (k_q + CW'(1) >= n_q) begin
						k_q <= '0;
						state_q <= ST_IDLE;
					end else k_q <= k_q + CW'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = state_q == ST_EMIT;
	assign tour_vertex = stack_q[k_q[VW-1:0]];
	assign tour_cost = (best_q > CostW'(CostSat)) ? CostSat : best_q[TourCostW-1:0];
	assign last_vertex = (k_q + CW'(1)) == n_q;
endmodule
